[hw/rtl/svag_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svag_pkg
// Shared constants and types of the sphere vertex attribute generator.
// ----------------------------------------------------------------------------
package svag_pkg;

    localparam int FRAC_BITS = 14;
    localparam int MAX_GRID  = 255;
    localparam int Q30_SHIFT = 30 - FRAC_BITS;
    localparam int Q60_SHIFT = 60 - FRAC_BITS;

    localparam int MIN_RINGS    = 3;
    localparam int MIN_SECTIONS = 4;

    // restoring divider: one quotient bit per cell
    localparam int DIV_W   = 40;
    localparam int NUM_DIV = 4;

    localparam int ANGLE_W = 32;
    localparam int X_W     = 31;
    localparam int X2_W    = 32;
    localparam int TERM_W  = 34;
    localparam int SUM_W   = 40;
    localparam int TRIG_W  = 32;
    localparam int V_W     = 36;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 36;

    localparam int SERIES_TERMS = 7;
    localparam int TERM_STAGES  = 3;
    localparam int SINCOS_LAT   = 2 + SERIES_TERMS * TERM_STAGES + 1;

    localparam logic [X_W-1:0]    HALF_PI_Q30 = 31'd1686629713;
    localparam logic [TERM_W-1:0] Q30_ONE     = 34'h0_4000_0000;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 32'sh4000_0000;

    localparam logic [2:0] MODE_POSITION  = 3'd0;
    localparam logic [2:0] MODE_NORMAL    = 3'd1;
    localparam logic [2:0] MODE_TANGENT   = 3'd2;
    localparam logic [2:0] MODE_BITANGENT = 3'd3;
    localparam logic [2:0] MODE_WRAP      = 3'd4;

    localparam logic [0:0] REG_RING_COUNT    = 1'b0;
    localparam logic [0:0] REG_SECTION_COUNT = 1'b1;

    typedef struct packed {
        logic [X2_W-1:0]   x2;
        logic [TERM_W-1:0] sin_term;
        logic [SUM_W-1:0]  sin_sum;
        logic [TERM_W-1:0] cos_term;
        logic [SUM_W-1:0]  cos_sum;
    } svag_series_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       err;
    } svag_tag_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic        err;
        logic [15:0] u;
        logic [15:0] v;
    } svag_side_t;

endpackage
`default_nettype wire

[hw/rtl/sphere_vertex_attribute_gen_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_vertex_attribute_gen_top
// UV sphere vertex attribute generator: position, normal, tangent, bitangent
// or wrap coordinates of one grid vertex, Q1.14 components.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless a stall on the output holds the
// whole pipeline, and returns results in order. Stages: the 40 cells of the
// restoring dividers that turn the grid indices into phases, the sine and
// cosine chain (seven three-stage Taylor term cells), then the product and
// rounding registers. Counts must be written through the configuration port
// only while no transaction is in flight; the block does not enforce it.
module sphere_vertex_attribute_gen_top
    import svag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  section_index,
    input  wire logic [7:0]  ring_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [15:0] comp_x,
    output logic signed [15:0] comp_y,
    output logic signed [15:0] comp_z,
    output logic             index_error,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int LAT = DIV_W + SINCOS_LAT + 2;

    logic [7:0]   ring_count_reg;
    logic [7:0]   section_count_reg;
    logic [7:0]   cnt_r;
    logic [7:0]   cnt_s;
    logic         en;
    logic         vld_reg [LAT];

    logic [7:0]       div_den [NUM_DIV];
    logic [7:0]       div_rem [NUM_DIV][DIV_W+1];
    logic [DIV_W-1:0] div_nq  [NUM_DIV][DIV_W+1];

    svag_tag_t    tag_in;
    svag_tag_t    tag_reg [DIV_W];
    svag_side_t   side_in;
    svag_side_t   side_reg [SINCOS_LAT];
    svag_side_t   side_c;

    logic [TRIG_W-1:0] lon_sin;
    logic [TRIG_W-1:0] lon_cos;
    logic [TRIG_W-1:0] lat_sin;
    logic [TRIG_W-1:0] lat_cos;

    logic signed [31:0] sl, cl, sr, cr;
    logic signed [31:0] ax, bx, ay, by, az, bz;
    logic signed [63:0] px_reg, py_reg, pz_reg;
    logic         half_reg;
    logic         wrap_reg;
    logic         err_p_reg;
    logic [15:0]  u_reg;
    logic [15:0]  v_reg;

    logic [15:0]  comp_x_next, comp_y_next, comp_z_next;
    logic [15:0]  comp_x_reg, comp_y_reg, comp_z_reg;
    logic         error_reg;

    function automatic logic [7:0] eff_count(input logic [7:0] v, input int lo);
        if (int'(v) < lo)
        begin
            return 8'(lo);
        end
        else if (int'(v) > MAX_GRID)
        begin
            return 8'(MAX_GRID);
        end
        return v;
    endfunction

    // half away from zero
    function automatic logic [15:0] round_q60(input logic signed [63:0] val,
                                              input logic half);
        logic [63:0] mag;
        logic [63:0] res;
        mag = val[63] ? 64'(-val) : 64'(val);
        if (half)
        begin
            res = (mag + (64'd1 << Q60_SHIFT)) >> (Q60_SHIFT + 1);
        end
        else
        begin
            res = (mag + (64'd1 << (Q60_SHIFT - 1))) >> Q60_SHIFT;
        end
        if (val[63])
        begin
            res = -res;
        end
        return res[15:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_count_reg    <= 8'd12;
            section_count_reg <= 8'd18;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_RING_COUNT:    ring_count_reg    <= cfg_data;
                REG_SECTION_COUNT: section_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cnt_r = eff_count(ring_count_reg, MIN_RINGS);
    assign cnt_s = eff_count(section_count_reg, MIN_SECTIONS);

    assign en       = !(vld_reg[LAT-1] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // phases in turns and wrap coordinates, all rounded half up
    assign div_den[0] = cnt_s;
    assign div_den[1] = cnt_r;
    assign div_den[2] = cnt_s;
    assign div_den[3] = cnt_r;
    assign div_nq[0][0] = {section_index, 32'd0} + DIV_W'(cnt_s >> 1);
    assign div_nq[1][0] = DIV_W'({ring_index, 31'd0}) + DIV_W'(cnt_r >> 1);
    assign div_nq[2][0] = DIV_W'({section_index, {FRAC_BITS{1'b0}}}) + DIV_W'(cnt_s >> 1);
    assign div_nq[3][0] = DIV_W'({ring_index, {FRAC_BITS{1'b0}}}) + DIV_W'(cnt_r >> 1);

    for (genvar d = 0; d < NUM_DIV; d++)
    begin : g_div
        assign div_rem[d][0] = 8'd0;
        for (genvar i = 0; i < DIV_W; i++)
        begin : g_step
            svag_div_cell u_cell (
                .clk     (clk),
                .en      (en),
                .divisor (div_den[d]),
                .rem_in  (div_rem[d][i]),
                .nq_in   (div_nq[d][i]),
                .rem_out (div_rem[d][i+1]),
                .nq_out  (div_nq[d][i+1])
            );
        end
    end

    assign tag_in.mode = mode;
    assign tag_in.err  = (section_index > cnt_s) || (ring_index > cnt_r);

    assign side_in.mode = tag_reg[DIV_W-1].mode;
    assign side_in.err  = tag_reg[DIV_W-1].err;
    assign side_in.u    = div_nq[2][DIV_W][15:0];
    assign side_in.v    = div_nq[3][DIV_W][15:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DIV_W; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
            side_reg[0] <= side_in;
            for (int i = 1; i < SINCOS_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    svag_sincos u_lon (
        .clk     (clk),
        .en      (en),
        .phase   (div_nq[0][DIV_W][ANGLE_W-1:0]),
        .sin_val (lon_sin),
        .cos_val (lon_cos)
    );

    svag_sincos u_lat (
        .clk     (clk),
        .en      (en),
        .phase   (div_nq[1][DIV_W][ANGLE_W-1:0]),
        .sin_val (lat_sin),
        .cos_val (lat_cos)
    );

    assign side_c = side_reg[SINCOS_LAT-1];
    assign sl = $signed(lon_sin);
    assign cl = $signed(lon_cos);
    assign sr = $signed(lat_sin);
    assign cr = $signed(lat_cos);

    // every component as a Q.60 product; plain Q.30 values are taken times one
    always_comb
    begin
        ax = '0;
        bx = '0;
        ay = '0;
        by = '0;
        az = '0;
        bz = '0;
        case (side_c.mode) inside
            MODE_POSITION, MODE_NORMAL:
            begin
                ax = sr;
                bx = cl;
                ay = cr;
                by = TRIG_ONE;
                az = -sr;
                bz = sl;
            end
            MODE_TANGENT:
            begin
                ax = -sl;
                bx = TRIG_ONE;
                az = -cl;
                bz = TRIG_ONE;
            end
            MODE_BITANGENT:
            begin
                ax = -cr;
                bx = cl;
                ay = sr;
                by = TRIG_ONE;
                az = cr;
                bz = sl;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (err_p_reg)
        begin
            comp_x_next = '0;
            comp_y_next = '0;
            comp_z_next = '0;
        end
        else if (wrap_reg)
        begin
            comp_x_next = u_reg;
            comp_y_next = v_reg;
            comp_z_next = '0;
        end
        else
        begin
            comp_x_next = round_q60(px_reg, half_reg);
            comp_y_next = round_q60(py_reg, half_reg);
            comp_z_next = round_q60(pz_reg, half_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg     <= ax * bx;
            py_reg     <= ay * by;
            pz_reg     <= az * bz;
            half_reg   <= (side_c.mode == MODE_POSITION);
            wrap_reg   <= (side_c.mode == MODE_WRAP);
            err_p_reg  <= side_c.err;
            u_reg      <= side_c.u;
            v_reg      <= side_c.v;

            comp_x_reg <= comp_x_next;
            comp_y_reg <= comp_y_next;
            comp_z_reg <= comp_z_next;
            error_reg  <= err_p_reg;
        end
    end

    assign out_valid   = vld_reg[LAT-1];
    assign comp_x      = $signed(comp_x_reg);
    assign comp_y      = $signed(comp_y_reg);
    assign comp_z      = $signed(comp_z_reg);
    assign index_error = error_reg;

endmodule
`default_nettype wire

[hw/rtl/svag_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svag_div_cell
// One step of a restoring divider: takes in one numerator bit, emits one
// quotient bit into the same shift word.
// ----------------------------------------------------------------------------
module svag_div_cell
    import svag_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [7:0]       divisor,
    input  wire logic [7:0]       rem_in,
    input  wire logic [DIV_W-1:0] nq_in,
    output logic [7:0]            rem_out,
    output logic [DIV_W-1:0]      nq_out
);

    logic [8:0]       trial;
    logic             fits;
    logic [7:0]       rem_reg;
    logic [7:0]       rem_next;
    logic [DIV_W-1:0] nq_reg;
    logic [DIV_W-1:0] nq_next;

    always_comb
    begin
        trial = {rem_in, nq_in[DIV_W-1]};
        fits  = (trial >= {1'b0, divisor});
        if (fits)
        begin
            rem_next = 8'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = trial[7:0];
        end
        nq_next = {nq_in[DIV_W-2:0], fits};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule
`default_nettype wire

[hw/rtl/svag_term_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svag_term_cell
// One Taylor term of sine and cosine: multiply by x squared, divide by the
// term's constant through a reciprocal, then accumulate.
// ----------------------------------------------------------------------------
module svag_term_cell
    import svag_pkg::*;
#(
    parameter int K = 1
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire svag_series_t series_in,
    output svag_series_t      series_out
);

    localparam int COS_DIV = (2 * K - 1) * (2 * K);
    localparam int SIN_DIV = (2 * K) * (2 * K + 1);
    localparam logic [7:0] COS_DIV_C = 8'(COS_DIV);
    localparam logic [7:0] SIN_DIV_C = 8'(SIN_DIV);
    localparam logic [RECIP_W-1:0] COS_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / COS_DIV);
    localparam logic [RECIP_W-1:0] SIN_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SIN_DIV);
    localparam bit SIN_ON   = (K < SERIES_TERMS);
    localparam bit SUBTRACT = ((K % 2) == 1);

    logic [TERM_W+X2_W-1:0]  sin_prod;
    logic [TERM_W+X2_W-1:0]  cos_prod;
    logic [V_W+RECIP_W-1:0]  sin_qprod;
    logic [V_W+RECIP_W-1:0]  cos_qprod;

    logic [X2_W-1:0]  s1_x2_reg;
    logic [V_W-1:0]   s1_sin_v_reg;
    logic [V_W-1:0]   s1_cos_v_reg;
    logic [SUM_W-1:0] s1_sin_sum_reg;
    logic [SUM_W-1:0] s1_cos_sum_reg;

    logic [X2_W-1:0]  s2_x2_reg;
    logic [V_W-1:0]   s2_sin_v_reg;
    logic [V_W-1:0]   s2_cos_v_reg;
    logic [V_W-1:0]   s2_sin_q_reg;
    logic [V_W-1:0]   s2_cos_q_reg;
    logic [SUM_W-1:0] s2_sin_sum_reg;
    logic [SUM_W-1:0] s2_cos_sum_reg;

    logic [V_W-1:0]   sin_rem;
    logic [V_W-1:0]   cos_rem;
    logic [V_W-1:0]   sin_q;
    logic [V_W-1:0]   cos_q;
    svag_series_t     out_next;
    svag_series_t     out_reg;

    assign sin_prod  = series_in.sin_term * series_in.x2;
    assign cos_prod  = series_in.cos_term * series_in.x2;
    assign sin_qprod = s1_sin_v_reg * SIN_RECIP;
    assign cos_qprod = s1_cos_v_reg * COS_RECIP;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x2_reg      <= series_in.x2;
            s1_sin_v_reg   <= sin_prod[30 +: V_W];
            s1_cos_v_reg   <= cos_prod[30 +: V_W];
            s1_sin_sum_reg <= series_in.sin_sum;
            s1_cos_sum_reg <= series_in.cos_sum;

            s2_x2_reg      <= s1_x2_reg;
            s2_sin_v_reg   <= s1_sin_v_reg;
            s2_cos_v_reg   <= s1_cos_v_reg;
            s2_sin_q_reg   <= sin_qprod[RECIP_SHIFT +: V_W];
            s2_cos_q_reg   <= cos_qprod[RECIP_SHIFT +: V_W];
            s2_sin_sum_reg <= s1_sin_sum_reg;
            s2_cos_sum_reg <= s1_cos_sum_reg;

            out_reg        <= out_next;
        end
    end

    // reciprocal estimate is at most one low
    always_comb
    begin
        sin_rem = V_W'(s2_sin_v_reg - V_W'(s2_sin_q_reg * SIN_DIV_C));
        cos_rem = V_W'(s2_cos_v_reg - V_W'(s2_cos_q_reg * COS_DIV_C));
        sin_q   = s2_sin_q_reg + V_W'(sin_rem >= V_W'(SIN_DIV_C));
        cos_q   = s2_cos_q_reg + V_W'(cos_rem >= V_W'(COS_DIV_C));

        out_next.x2       = s2_x2_reg;
        out_next.sin_term = TERM_W'(sin_q);
        out_next.cos_term = TERM_W'(cos_q);
        if (SUBTRACT)
        begin
            out_next.cos_sum = s2_cos_sum_reg - SUM_W'(cos_q);
            out_next.sin_sum = s2_sin_sum_reg - SUM_W'(sin_q);
        end
        else
        begin
            out_next.cos_sum = s2_cos_sum_reg + SUM_W'(cos_q);
            out_next.sin_sum = s2_sin_sum_reg + SUM_W'(sin_q);
        end
        if (!SIN_ON)
        begin
            out_next.sin_sum = s2_sin_sum_reg;
        end
    end

    assign series_out = out_reg;

endmodule
`default_nettype wire

[hw/rtl/svag_sincos.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// svag_sincos
// Sine and cosine of a 32-bit phase in turns, Q.30 results, by a chain of
// Taylor term cells on the first quadrant and a quadrant fold.
// ----------------------------------------------------------------------------
module svag_sincos
    import svag_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [ANGLE_W-1:0] phase,
    output logic [TRIG_W-1:0]       sin_val,
    output logic [TRIG_W-1:0]       cos_val
);

    localparam int QUAD_DLY = SERIES_TERMS * TERM_STAGES;

    logic [X_W+30-1:0]  x_prod;
    logic [2*X_W-1:0]   xx_prod;
    logic [X_W-1:0]     x_a_reg;
    logic [1:0]         quad_a_reg;
    svag_series_t       series_b_reg;
    svag_series_t       series_next;
    logic [1:0]         quad_reg [QUAD_DLY+1];
    svag_series_t       series_w [SERIES_TERMS+1];
    logic [TRIG_W-1:0]  s_clamp;
    logic [TRIG_W-1:0]  c_clamp;
    logic [TRIG_W-1:0]  sin_next;
    logic [TRIG_W-1:0]  cos_next;
    logic [TRIG_W-1:0]  sin_reg;
    logic [TRIG_W-1:0]  cos_reg;

    function automatic logic [TRIG_W-1:0] clamp_q30(input logic [SUM_W-1:0] sum);
        if (sum[SUM_W-1])
        begin
            return '0;
        end
        else if (sum > SUM_W'(Q30_ONE))
        begin
            return TRIG_W'(Q30_ONE);
        end
        return sum[TRIG_W-1:0];
    endfunction

    // low 30 bits of phase to radians, Q1.30
    assign x_prod  = phase[29:0] * HALF_PI_Q30;
    assign xx_prod = x_a_reg * x_a_reg;

    always_comb
    begin
        series_next.x2       = xx_prod[30 +: X2_W];
        series_next.sin_term = TERM_W'(x_a_reg);
        series_next.sin_sum  = SUM_W'(x_a_reg);
        series_next.cos_term = Q30_ONE;
        series_next.cos_sum  = SUM_W'(Q30_ONE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg      <= x_prod[30 +: X_W];
            quad_a_reg   <= phase[31:30];
            series_b_reg <= series_next;
            quad_reg[0]  <= quad_a_reg;
            for (int i = 1; i <= QUAD_DLY; i++)
            begin
                quad_reg[i] <= quad_reg[i-1];
            end
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign series_w[0] = series_b_reg;

    for (genvar k = 1; k <= SERIES_TERMS; k++)
    begin : g_term
        svag_term_cell #(
            .K (k)
        ) u_term (
            .clk        (clk),
            .en         (en),
            .series_in  (series_w[k-1]),
            .series_out (series_w[k])
        );
    end

    always_comb
    begin
        s_clamp = clamp_q30(series_w[SERIES_TERMS].sin_sum);
        c_clamp = clamp_q30(series_w[SERIES_TERMS].cos_sum);
        case (quad_reg[QUAD_DLY])
            2'd0:
            begin
                sin_next = s_clamp;
                cos_next = c_clamp;
            end
            2'd1:
            begin
                sin_next = c_clamp;
                cos_next = -s_clamp;
            end
            2'd2:
            begin
                sin_next = -s_clamp;
                cos_next = -c_clamp;
            end
            default:
            begin
                sin_next = -c_clamp;
                cos_next = s_clamp;
            end
        endcase
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule
`default_nettype wire

[tb/sv/sphere_vertex_attribute_gen_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_vertex_attribute_gen_checker
// Watches both channels of the sphere vertex attribute generator, predicts the
// attribute of every accepted vertex and compares it with the returned result.
// ----------------------------------------------------------------------------
module sphere_vertex_attribute_gen_checker
    import svag_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  section_index,
    input  wire logic [7:0]  ring_index,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic signed [15:0] comp_x,
    input  wire logic signed [15:0] comp_y,
    input  wire logic signed [15:0] comp_z,
    input  wire logic        index_error,
    input  wire logic        cfg_wr_en,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output int               fail_count,
    output int               pending_attrs
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        err;
    } vertex_attr_t;

    vertex_attr_t expected_attrs[$];
    logic [7:0]   rings_reg;
    logic [7:0]   sections_reg;

    function automatic longint taylor_sum(longint unsigned x, longint unsigned x2,
                                          bit want_cos);
        longint unsigned term;
        longint unsigned a;
        longint          acc;
        term = want_cos ? 64'd1 << 30 : x;
        acc = longint'(term);
        for (int k = 1; k <= (want_cos ? 7 : 6); k++)
        begin
            a = 64'(want_cos ? 2 * k - 1 : 2 * k);
            term = ((term * x2) >> 30) / (a * (a + 1));
            if (k % 2 == 1)
                acc -= longint'(term);
            else
                acc += longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (64'sd1 <<< 30))
            acc = 64'sd1 <<< 30;
        return acc;
    endfunction

    function automatic void phase_sin_cos(input logic [31:0] phase, output longint sn,
                                          output longint cs);
        longint unsigned x;
        longint unsigned x2;
        longint          s;
        longint          c;
        x = (longint'(phase[29:0]) * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        s = taylor_sum(x, x2, 1'b0);
        c = taylor_sum(x, x2, 1'b1);
        case (phase[31:30])
            2'd0: begin sn = s;  cs = c;  end
            2'd1: begin sn = c;  cs = -s; end
            2'd2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic logic [15:0] round_away(longint v, int sh);
        longint unsigned m;
        m = v < 0 ? longint'(-v) : longint'(v);
        if (sh > 0)
            m = (m + (64'd1 << (sh - 1))) >> sh;
        if (v < 0)
            m = -m;
        return m[15:0];
    endfunction

    function automatic vertex_attr_t sphere_attr(logic [2:0] md, logic [7:0] s_idx,
                                                 logic [7:0] r_idx);
        vertex_attr_t    res;
        longint unsigned ns;
        longint unsigned nr;
        longint unsigned tmp;
        longint          sl, cl, sr, cr;
        ns = sections_reg < MIN_SECTIONS ? MIN_SECTIONS : sections_reg;
        nr = rings_reg < MIN_RINGS ? MIN_RINGS : rings_reg;
        res = '0;
        if (s_idx > ns || r_idx > nr)
        begin
            res.err = 1'b1;
            return res;
        end
        tmp = ((longint'(s_idx) << 32) + ns / 2) / ns;
        phase_sin_cos(tmp[31:0], sl, cl);
        tmp = ((longint'(r_idx) << 31) + nr / 2) / nr;
        phase_sin_cos(tmp[31:0], sr, cr);
        case (md)
            MODE_POSITION:
            begin
                res.x = round_away(sr * cl, Q60_SHIFT + 1);
                res.y = round_away(cr, Q30_SHIFT + 1);
                res.z = round_away(-(sr * sl), Q60_SHIFT + 1);
            end
            MODE_NORMAL:
            begin
                res.x = round_away(sr * cl, Q60_SHIFT);
                res.y = round_away(cr, Q30_SHIFT);
                res.z = round_away(-(sr * sl), Q60_SHIFT);
            end
            MODE_TANGENT:
            begin
                res.x = round_away(-sl, Q30_SHIFT);
                res.z = round_away(-cl, Q30_SHIFT);
            end
            MODE_BITANGENT:
            begin
                res.x = round_away(-(cr * cl), Q60_SHIFT);
                res.y = round_away(sr, Q30_SHIFT);
                res.z = round_away(cr * sl, Q60_SHIFT);
            end
            MODE_WRAP:
            begin
                tmp = ((longint'(s_idx) << FRAC_BITS) + ns / 2) / ns;
                res.x = tmp[15:0];
                tmp = ((longint'(r_idx) << FRAC_BITS) + nr / 2) / nr;
                res.y = tmp[15:0];
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        vertex_attr_t want;
        if (!rst_n)
        begin
            rings_reg = 8'd12;
            sections_reg = 8'd18;
            fail_count = 0;
            expected_attrs.delete();
            pending_attrs = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_RING_COUNT)
                    rings_reg = cfg_data;
                else
                    sections_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                expected_attrs.push_back(sphere_attr(mode, section_index, ring_index));
            if (out_valid && !out_stall)
            begin
                if (expected_attrs.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_attrs.pop_front();
                    if (comp_x !== want.x)
                    begin
                        $error("comp_x expected %0d actual %0d", $signed(want.x), comp_x);
                        fail_count++;
                    end
                    if (comp_y !== want.y)
                    begin
                        $error("comp_y expected %0d actual %0d", $signed(want.y), comp_y);
                        fail_count++;
                    end
                    if (comp_z !== want.z)
                    begin
                        $error("comp_z expected %0d actual %0d", $signed(want.z), comp_z);
                        fail_count++;
                    end
                    if (index_error !== want.err)
                    begin
                        $error("index_error expected %0d actual %0d", want.err,
                               index_error);
                        fail_count++;
                    end
                end
            end
            pending_attrs = expected_attrs.size();
        end
    end

endmodule

[tb/sv/sphere_vertex_attribute_gen_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_vertex_attribute_gen_top_test
// Drives vertex queries under several ring and section counts with random
// gaps and output stalls; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module sphere_vertex_attribute_gen_top_test
    import svag_pkg::*;
();

    localparam int PIPE_DEPTH = 66;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  mode;
    logic [7:0]  section_index;
    logic [7:0]  ring_index;
    logic        out_valid;
    logic        out_stall;
    logic signed [15:0] comp_x;
    logic signed [15:0] comp_y;
    logic signed [15:0] comp_z;
    logic        index_error;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [7:0]  cfg_data;
    int          fail_count;
    int          pending_attrs;
    logic [7:0]  cur_rings;
    logic [7:0]  cur_sections;
    bit          stall_enable;

    sphere_vertex_attribute_gen_top i_dut (.*);

    sphere_vertex_attribute_gen_checker i_checker (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls, switched off now and then for clean stretches
    always @(negedge clk)
    begin
        if (stall_enable && $urandom_range(0, 3) == 0)
            out_stall <= (gap_len() != 0);
        else
            out_stall <= 1'b0;
    end

    // valid stays high after the accepting edge; a gap in the next call or drain drops it
    task automatic send_vertex(logic [2:0] md, logic [7:0] s_idx, logic [7:0] r_idx);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        section_index <= s_idx;
        ring_index <= r_idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_attrs != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 4) @(negedge clk);
    endtask

    task automatic write_counts(logic [7:0] rings, logic [7:0] sections);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_RING_COUNT;
        cfg_data <= rings;
        @(negedge clk);
        cfg_index <= REG_SECTION_COUNT;
        cfg_data <= sections;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_rings = rings;
        cur_sections = sections;
    endtask

    task automatic random_vertices(int n);
        logic [7:0] ns;
        logic [7:0] nr;
        logic [2:0] md;
        logic [7:0] s_idx;
        logic [7:0] r_idx;
        ns = cur_sections < MIN_SECTIONS ? 8'(MIN_SECTIONS) : cur_sections;
        nr = cur_rings < MIN_RINGS ? 8'(MIN_RINGS) : cur_rings;
        for (int i = 0; i < n; i++)
        begin
            md = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if ($urandom_range(0, 9) == 0)
            begin
                s_idx = 8'($urandom);
                r_idx = 8'($urandom);
            end
            else
            begin
                s_idx = 8'($urandom_range(0, ns));
                r_idx = 8'($urandom_range(0, nr));
            end
            send_vertex(md, s_idx, r_idx);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = '0;
        section_index = '0;
        ring_index = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_rings = 8'd12;
        cur_sections = 8'd18;
        stall_enable = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: every mode at reset counts, poles, seam, out of range
        for (int m = 0; m < 8; m++)
            send_vertex(3'(m), 8'd5, 8'd4);
        send_vertex(MODE_NORMAL, 8'd0, 8'd0);
        send_vertex(MODE_NORMAL, 8'd18, 8'd12);
        send_vertex(MODE_BITANGENT, 8'd9, 8'd6);
        send_vertex(MODE_WRAP, 8'd18, 8'd12);
        send_vertex(MODE_POSITION, 8'd19, 8'd3);
        send_vertex(MODE_TANGENT, 8'd2, 8'd13);
        send_vertex(MODE_WRAP, 8'hff, 8'hff);
        send_vertex(3'd7, 8'hff, 8'd0);
        send_vertex(MODE_POSITION, 8'd13, 8'd7);
        drain();

        // counts below the minimum clamp up
        write_counts(8'd0, 8'd0);
        send_vertex(MODE_WRAP, 8'd4, 8'd3);
        send_vertex(MODE_NORMAL, 8'd5, 8'd2);
        send_vertex(MODE_POSITION, 8'd1, 8'd4);
        random_vertices(40);
        drain();

        stall_enable = 1'b1;
        write_counts(8'd255, 8'd255);
        send_vertex(MODE_WRAP, 8'd255, 8'd255);
        send_vertex(MODE_NORMAL, 8'd170, 8'd85);
        random_vertices(100);
        drain();

        write_counts(8'd3, 8'd4);
        random_vertices(80);
        drain();

        write_counts(8'd12, 8'd18);
        random_vertices(60);
        stall_enable = 1'b0;
        random_vertices(40);
        drain();

        stall_enable = 1'b1;
        for (int p = 0; p < 4; p++)
        begin
            write_counts(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            random_vertices(45);
            drain();
        end

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
